// File: src/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types and codes for the indexed double-ended queue.
// ----------------------------------------------------------------------------
package idq_pkg;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_POP_BACK   = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_READ       = 3'd4,
        REQ_WRITE      = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADLOC = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // capture an accepted request
        logic exec;   // carry out the captured request
    } t_dp_cmd;

endpackage

// File: src/idq_ctrl.sv
// ----------------------------------------------------------------------------
// idq_ctrl
// Sequencer: accept, execute, present the result.
// ----------------------------------------------------------------------------
module idq_ctrl import idq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_done,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // result shown this cycle; the next request may enter now
                n_state = start ? ST_EXEC : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy       = (r_state == ST_EXEC);
        o_done     = (r_state == ST_DONE);
        o_cmd.load = start && (r_state != ST_EXEC);
        o_cmd.exec = (r_state == ST_EXEC);
    end

endmodule

// File: src/idq_dp.sv
// ----------------------------------------------------------------------------
// idq_dp
// Ring store, front pointer, element count and result registers.
// ----------------------------------------------------------------------------
module idq_dp import idq_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [POS_W-1:0]    i_position,
    input  logic [DATA_W-1:0]   i_write_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_read_value,
    output logic [COUNT_W-1:0]  o_element_count
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OFF_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W = OFF_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM   = SUM_W'(CAPACITY);

    logic [WORD_WIDTH-1:0] r_mem [CAPACITY];

    logic [REQ_W-1:0]      r_req;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_W-1:0]     r_val;
    logic [PTR_W-1:0]      r_front;
    logic [CNT_W-1:0]      r_count;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_rd_ok;
    logic [WORD_WIDTH-1:0] r_rd_data;

    logic [PTR_W-1:0]    n_front;
    logic [CNT_W-1:0]    n_count;
    logic [STATUS_W-1:0] n_status;
    logic                n_rd_ok;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [OFF_W-1:0]    offset;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    sum_wrap;
    logic [PTR_W-1:0]    slot;
    logic [PTR_W-1:0]    front_dec;
    logic [PTR_W-1:0]    front_inc;
    logic                is_full;
    logic                is_empty;
    logic                pos_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_val <= i_write_value;
        end
    end

    // logical offset to ring slot; offset is below 2*CAPACITY when it matters
    always_comb begin
        offset    = (t_req'(r_req) == REQ_PUSH_BACK) ? OFF_W'(r_count) : OFF_W'(r_pos);
        sum       = SUM_W'(r_front) + SUM_W'(offset);
        sum_wrap  = (sum >= CAP_SUM) ? (sum - CAP_SUM) : sum;
        slot      = sum_wrap[PTR_W-1:0];
        front_dec = (r_front == '0) ? LAST_SLOT : (r_front - PTR_W'(1));
        front_inc = (r_front == LAST_SLOT) ? '0 : (r_front + PTR_W'(1));
        is_full   = (r_count == FULL_CNT);
        is_empty  = (r_count == '0);
        pos_ok    = (OFF_W'(r_pos) < OFF_W'(r_count));
    end

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = STAT_OK;
        n_rd_ok  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = slot;
        unique case (r_req)
            REQ_PUSH_BACK: begin
                if (is_full) begin
                    n_status = STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (is_empty) n_status = STAT_EMPTY;
                else          n_count  = r_count - CNT_W'(1);
            end
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                    n_front = front_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (is_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - CNT_W'(1);
                end
            end
            REQ_READ: begin
                if (pos_ok) n_rd_ok  = 1'b1;
                else        n_status = STAT_BADLOC;
            end
            REQ_WRITE: begin
                if (pos_ok) wr_en    = 1'b1;
                else        n_status = STAT_BADLOC;
            end
            default: begin
                n_status = STAT_BADLOC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= WORD_WIDTH'(r_val);
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[slot];
        end
    end

    assign o_status        = r_status;
    assign o_read_value    = r_rd_ok ? DATA_W'(r_rd_data) : '0;
    assign o_element_count = COUNT_W'(r_count);

endmodule

// File: src/indexed_double_ended_queue.sv
// ----------------------------------------------------------------------------
// indexed_double_ended_queue
// Bounded deque of words with push/pop at both ends and indexed read/write.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It is executed in the
// following cycle (one store access: a write, or a registered read), and its
// result appears in the cycle after that on o_status, o_read_value and
// o_element_count with o_done high for exactly that cycle. busy is high only
// in the execute cycle, so a new request may be issued while a result is
// shown, but not while one is executing. Results cannot be held off; sample
// them whenever o_done is high. Front and back are read as index 0 and count
// minus 1. Store contents are undefined after reset, but only written entries
// are ever reachable.
module indexed_double_ended_queue import idq_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [POS_W-1:0]    i_position,
    input  logic [DATA_W-1:0]   i_write_value,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_read_value,
    output logic [COUNT_W-1:0]  o_element_count
);

    t_dp_cmd cmd;

    idq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    idq_dp #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req_type),
        .i_position      (i_position),
        .i_write_value   (i_write_value),
        .o_status        (o_status),
        .o_read_value    (o_read_value),
        .o_element_count (o_element_count)
    );

endmodule

// File: src/idq_chk.sv
// ----------------------------------------------------------------------------
// idq_chk
// Port-level checks for the indexed double-ended queue, bound to the top.
// ----------------------------------------------------------------------------
module idq_chk import idq_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [STATUS_W-1:0] o_status,
    input logic [DATA_W-1:0]   o_read_value,
    input logic [COUNT_W-1:0]  o_element_count
);

    // every accepted transaction is executed next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // and its result follows in the cycle after that
    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_done)
        else $error("result missing two cycles after acceptance");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != STAT_OK) |-> (o_read_value == '0))
        else $error("rejected transaction returned data");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (int'(o_element_count) <= CAPACITY) || (CAPACITY >= 512))
        else $error("element count above capacity");

endmodule

bind indexed_double_ended_queue idq_chk #(.CAPACITY(CAPACITY)) u_idq_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_read_value    (o_read_value),
    .o_element_count (o_element_count)
);

// File: bench/indexed_double_ended_queue_test.sv
// ----------------------------------------------------------------------------
// indexed_double_ended_queue_test
// Self-checking bench for the indexed deque. A shadow ring store predicts
// status, read data and count for every accepted request; each o_done
// transaction is checked against the oldest prediction. Directed corner
// cases come first, then a fill to capacity and a drain, then a long random
// mix that swings the count up and down.
// ----------------------------------------------------------------------------
module indexed_double_ended_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import idq_pkg::*;

    localparam int DEPTH = 256;
    localparam int RANDOM_ITEMS = 1400;
    localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
    } t_outcome;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type = '0;
    logic [POS_W-1:0]    i_position = '0;
    logic [DATA_W-1:0]   i_write_value = '0;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_read_value;
    logic [COUNT_W-1:0]  o_element_count;

    // shadow of the deque contents
    logic [DATA_W-1:0]  shadow_store [DEPTH];
    logic [POS_W-1:0]   shadow_front = '0;
    logic [COUNT_W-1:0] shadow_count = '0;

    t_outcome pending_results[$];
    int       mismatch_count = 0;
    bit       steady = 1'b0;

    indexed_double_ended_queue #(
        .CAPACITY   (DEPTH),
        .WORD_WIDTH (DATA_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_position      (i_position),
        .i_write_value   (i_write_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_value    (o_read_value),
        .o_element_count (o_element_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("indexed_double_ended_queue verification failed");
        $finish;
    end

    // applies one request to the shadow deque and returns what it should report
    function automatic t_outcome deque_apply(input logic [REQ_W-1:0] req,
                                             input logic [POS_W-1:0] pos,
                                             input logic [DATA_W-1:0] val);
        t_outcome         r;
        logic [POS_W-1:0] slot;
        r.status = STAT_OK;
        r.read_value = '0;
        case (req)
            REQ_PUSH_BACK: begin
                if (shadow_count == DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    slot = shadow_front + shadow_count[POS_W-1:0];
                    shadow_store[slot] = val;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (shadow_count == 0) r.status = STAT_EMPTY;
                else shadow_count = shadow_count - 1'b1;
            end
            REQ_PUSH_FRONT: begin
                if (shadow_count == DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_front = shadow_front - 1'b1;
                    shadow_store[shadow_front] = val;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    shadow_front = shadow_front + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            REQ_READ: begin
                if ({1'b0, pos} >= shadow_count) begin
                    r.status = STAT_BADLOC;
                end else begin
                    slot = shadow_front + pos;
                    r.read_value = shadow_store[slot];
                end
            end
            REQ_WRITE: begin
                if ({1'b0, pos} >= shadow_count) begin
                    r.status = STAT_BADLOC;
                end else begin
                    slot = shadow_front + pos;
                    shadow_store[slot] = val;
                end
            end
            default: r.status = STAT_BADLOC;
        endcase
        r.count = shadow_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // one request transaction; start is left high so back-to-back issue works
    task automatic issue(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val);
        int gap;
        if (!steady && $urandom_range(99) < 15) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_req_type    <= req;
        i_position    <= pos;
        i_write_value <= val;
        do @(posedge i_clk); while (busy);
        pending_results.insert(pending_results.size(), deque_apply(req, pos, val));
    endtask

    // hold off until every outstanding result has come back
    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] valid_position;
        if (shadow_count == 0) return POS_W'($urandom_range(255));
        return POS_W'($urandom_range(shadow_count - 1));
    endfunction

    function automatic logic [REQ_W-1:0] either_end(input logic [REQ_W-1:0] back_req,
                                                     input logic [REQ_W-1:0] front_req);
        return $urandom_range(1) ? back_req : front_req;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && $isunknown(o_done)) begin
            report_mismatch("o_done unknown");
        end else if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                if (o_read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              o_read_value, want.read_value));
                if (o_element_count !== want.count)
                    report_mismatch($sformatf("element_count %0d, expected %0d",
                                              o_element_count, want.count));
            end
        end
    end

    // pops, reads and writes on an empty deque, plus undefined request codes
    task automatic test_empty_requests;
        issue(REQ_POP_BACK, 8'd0, 32'h0);
        issue(REQ_POP_FRONT, 8'd0, 32'h0);
        issue(REQ_READ, 8'd0, 32'h0);
        issue(REQ_WRITE, 8'd0, 32'hDEAD_BEEF);
        issue(REQ_READ, 8'hFF, 32'hFFFF_FFFF);
        issue(REQ_UNDEF_LO, 8'd0, 32'h1234_5678);
        issue(REQ_UNDEF_HI, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // both ends with extreme words; push front from pointer zero wraps the ring
    task automatic test_end_values;
        issue(REQ_PUSH_BACK, 8'd0, 32'hFFFF_FFFF);
        issue(REQ_PUSH_FRONT, 8'hFF, 32'h0000_0000);
        issue(REQ_PUSH_BACK, 8'd0, 32'hA5A5_5A5A);
        issue(REQ_READ, 8'd0, 32'h0);
        issue(REQ_READ, 8'd2, 32'h0);
        issue(REQ_READ, 8'd3, 32'h0);
        issue(REQ_WRITE, 8'd1, 32'h8000_0001);
        issue(REQ_READ, 8'd1, 32'h0);
        issue(REQ_WRITE, 8'hFF, 32'h5555_AAAA);
        issue(REQ_POP_FRONT, 8'd0, 32'h0);
        issue(REQ_POP_BACK, 8'd0, 32'h0);
        issue(REQ_READ, 8'd0, 32'h0);
        issue(REQ_POP_BACK, 8'd0, 32'h0);
        issue(REQ_POP_FRONT, 8'd0, 32'h0);
    endtask

    // fill to capacity, hit the full case at both ends, then empty it again
    task automatic test_fill_and_drain;
        while (shadow_count < DEPTH)
            issue(either_end(REQ_PUSH_BACK, REQ_PUSH_FRONT), 8'd0, $urandom);
        issue(REQ_PUSH_BACK, 8'd0, $urandom);
        issue(REQ_PUSH_FRONT, 8'd0, $urandom);
        issue(REQ_READ, 8'hFF, 32'h0);
        issue(REQ_WRITE, 8'hFF, $urandom);
        issue(REQ_READ, 8'hFF, 32'h0);
        issue(REQ_READ, 8'd0, 32'h0);
        repeat (10) issue(REQ_READ, valid_position(), 32'h0);
        while (shadow_count != 0) begin
            if ($urandom_range(9) == 0)
                issue(REQ_READ, valid_position(), 32'h0);
            issue(either_end(REQ_POP_BACK, REQ_POP_FRONT), 8'd0, 32'h0);
        end
    endtask

    // random walk of the count, biased in bursts towards growth or shrinkage
    task automatic test_random_mix;
        int               bias;
        int               pick;
        int               push_w;
        int               pop_w;
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] pos;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n < 300);
            if (n % 50 == 0) bias = $urandom_range(2);
            if (n == 700) drain();
            push_w = (bias == 0) ? 60 : (bias == 1) ? 15 : 35;
            pop_w  = (bias == 0) ? 15 : (bias == 1) ? 60 : 35;
            pick = $urandom_range(99);
            if (pick < push_w)
                req = either_end(REQ_PUSH_BACK, REQ_PUSH_FRONT);
            else if (pick < push_w + pop_w)
                req = either_end(REQ_POP_BACK, REQ_POP_FRONT);
            else if (pick < 97)
                req = $urandom_range(1) ? REQ_READ : REQ_WRITE;
            else
                req = $urandom_range(1) ? REQ_UNDEF_LO : REQ_UNDEF_HI;
            pos = ($urandom_range(9) < 8) ? valid_position() : POS_W'($urandom_range(255));
            issue(req, pos, $urandom);
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_requests();
        test_end_values();
        drain();
        test_fill_and_drain();
        drain();
        test_random_mix();
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("indexed_double_ended_queue verification clean");
        else
            $display("indexed_double_ended_queue verification failed");
        $finish;
    end

endmodule
